// ===== design/lef3_pkg.sv =====
// Shared types and constants for the 3x3 Laplacian edge filter.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lef3_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef logic [PIX_W-1:0] pixel_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_MAX_LEVEL    = 2'd2
  } cfg_reg_t;

  // Position flags for one accepted pixel
  typedef struct packed {
    logic res;   // pixel completes an interior window
    logic last;  // that window is the final one of the image
  } pos_info_t;

  // One new window column: two rows from the line stores and the incoming pixel
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

endpackage

`default_nettype wire

// ===== design/lef3_pos.sv =====
// Column and row counters of the edge filter, with border and end-of-image flags.
// Depends on lef3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lef3_pos #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              advance,
  input  wire logic                              frame_start,
  input  wire logic [lef3_pkg::DIM_W-1:0]        image_width,
  input  wire logic [lef3_pkg::DIM_W-1:0]        image_height,
  output logic      [$clog2(MAX_WIDTH)-1:0]      col_idx,
  output lef3_pkg::pos_info_t                    info
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int HW0 = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = (WW0 > lef3_pkg::DIM_W) ? WW0 : lef3_pkg::DIM_W;
  localparam int HW  = (HW0 > lef3_pkg::DIM_W) ? HW0 : lef3_pkg::DIM_W;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [WW-1:0] w_ext, w_eff, w_last, col_x;
  logic [HW-1:0] h_ext, h_eff, h_last, row_x;
  logic          col_end;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  // Saturate the programmed size to 3..MAX
  always_comb begin
    w_ext = WW'(image_width);
    h_ext = HW'(image_height);
    if (w_ext < WW'(3)) begin
      w_eff = WW'(3);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < HW'(3)) begin
      h_eff = HW'(3);
    end else if (h_ext > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    w_last = w_eff - WW'(1);
    h_last = h_eff - HW'(1);
  end

  assign col_cur = frame_start ? '0 : col;
  assign row_cur = frame_start ? '0 : row;
  assign col_x   = WW'(col_cur);
  assign row_x   = HW'(row_cur);
  assign col_idx = col_cur;

  assign info.res  = (row_x >= HW'(2)) && (col_x >= WW'(2)) && (col_x < w_eff) && (row_x < h_eff);
  assign info.last = (row_x == h_last) && (col_x == w_last);

  // A column at or past the last one ends the row
  always_comb begin
    col_end = (col_x >= w_last);
    if (col_end) begin
      col_next = '0;
      row_next = (row_x >= h_last) ? '0 : row_cur + RW'(1);
    end else begin
      col_next = col_cur + CW'(1);
      row_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/lef3_line_buf.sv =====
// Two line stores of the edge filter: the row above and the row two above.
// Depends on lef3_pkg; read data is registered, with a bypass for the upper store.
`timescale 1ns / 1ps
`default_nettype none

module lef3_line_buf #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  wire lef3_pkg::pixel_t             pixel,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output lef3_pkg::pixel_t                  mid,
  output lef3_pkg::pixel_t                  top
);

  lef3_pkg::pixel_t line0 [MAX_WIDTH];
  lef3_pkg::pixel_t line1 [MAX_WIDTH];

  // Previous row: read old value, store the new pixel
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid          <= line0[addr];
      line0[addr]  <= pixel;
    end
  end

  // Row two above: fed from the previous row's registered read data on wr_en
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line1[wr_addr] <= mid;
    end
    if (rd_en) begin
      top <= (wr_en && (wr_addr == addr)) ? mid : line1[addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/lef3_kernel.sv =====
// 3x3 window and 4-neighbour Laplacian with clamp and inversion.
// Depends on lef3_pkg; the window shifts in one column per advance.
`timescale 1ns / 1ps
`default_nettype none

module lef3_kernel (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              shift,
  input  wire lef3_pkg::column_t col_in,
  input  wire lef3_pkg::pixel_t  max_level,
  output lef3_pkg::pixel_t       edge_value
);

  // Only the taps the kernel reads are kept: middle column and the left tap
  lef3_pkg::pixel_t win_top, win_mid, win_bot, win_left;
  logic signed [11:0] lap;
  lef3_pkg::pixel_t   clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_top  <= '0;
      win_mid  <= '0;
      win_bot  <= '0;
      win_left <= '0;
    end else if (shift) begin
      win_top  <= col_in.top;
      win_mid  <= col_in.mid;
      win_bot  <= col_in.bot;
      win_left <= win_mid;
    end
  end

  // After the shift: up = win_top, down = win_bot, left = win_left,
  // right = incoming mid, centre = win_mid
  always_comb begin
    lap = $signed({4'b0, win_top}) + $signed({4'b0, win_bot})
        + $signed({4'b0, win_left}) + $signed({4'b0, col_in.mid})
        - $signed({2'b0, win_mid, 2'b0});
    if (lap[11]) begin
      clamped = '0;
    end else if (lap[10:0] > {3'b0, max_level}) begin
      clamped = max_level;
    end else begin
      clamped = lap[7:0];
    end
    edge_value = max_level - clamped;
  end

endmodule

`default_nettype wire

// ===== design/laplacian_edge_filter_3x3_core.sv =====
// Top level of the streaming 3x3 Laplacian edge filter.
// Depends on lef3_pkg, lef3_pos, lef3_line_buf and lef3_kernel.
//
// Usage:
//   Slave stream carries grey pixels in raster order, one per beat; tuser marks
//   the first pixel of an image and restarts the counters. Without it the
//   counters wrap after the last pixel, so images may follow back to back.
//   Master stream carries one result per interior pixel; border positions
//   give no beat. tlast is high on the final result of each image.
//   Configuration (width, height, maximum level) is written on cfg_we with
//   cfg_addr selecting the register; write only while the filter is idle.
// Timing:
//   One pixel per clock is sustained while the receiver keeps m_tready high.
//   An accepted pixel is registered in the line store stage beside the line store read
//   data; when the kernel stage advances, the window shifts and the kernel result is loaded into the output register.
// Reset:
//   Synchronous; clears counters, window and both pipeline valids and loads
//   the default size 640 x 480 and maximum level 255. Line stores are not
//   cleared; every entry read within an image has been written in it.
// Back-pressure:
//   When the receiver holds tready low the output register holds its beat;
//   the line store stage keeps one more pixel and then drops s_tready.
`timescale 1ns / 1ps
`default_nettype none

module laplacian_edge_filter_3x3_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [lef3_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [lef3_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // pixel stream in
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [7:0]                          s_tdata,   // [7:0] pixel
  input  wire logic                                s_tuser,   // frame_start
  // result stream out
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [7:0]                               m_tdata,   // [7:0] edge_value
  output logic                                     m_tlast    // last_of_frame
);

  localparam int AW = $clog2(MAX_WIDTH);

  // configuration registers
  logic [lef3_pkg::DIM_W-1:0] image_width;
  logic [lef3_pkg::DIM_W-1:0] image_height;
  lef3_pkg::pixel_t           max_level;

  // handshakes
  logic accept;
  logic advance_b;

  // position of the pixel being accepted
  logic [AW-1:0]       col_idx;
  lef3_pkg::pos_info_t info;

  // line store stage
  logic                valid_a;
  logic [AW-1:0]       idx_a;
  lef3_pkg::pos_info_t info_a;
  lef3_pkg::pixel_t    pixel_a;
  lef3_pkg::pixel_t    mid_a, top_a;
  lef3_pkg::column_t   column_a;

  // kernel and output register
  lef3_pkg::pixel_t edge_value;
  logic             out_valid;
  lef3_pkg::pixel_t out_edge;
  logic             out_last;

  // Configuration: indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lef3_pkg::DIM_W'(640);
      image_height <= lef3_pkg::DIM_W'(480);
      max_level    <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_addr)
        lef3_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        lef3_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        lef3_pkg::CFG_MAX_LEVEL:    max_level    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Advance the kernel stage when the line store stage is full and the output register is free or being drained;
  // take a new pixel whenever the line store stage is empty or moving on.
  assign advance_b = valid_a && (!out_valid || m_tready);
  assign s_tready  = !valid_a || advance_b;
  assign accept    = s_tvalid && s_tready;

  lef3_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .frame_start  (s_tuser),
    .image_width  (image_width),
    .image_height (image_height),
    .col_idx      (col_idx),
    .info         (info)
  );

  // Upper store is written from the kernel stage, at the address of its pixel
  lef3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .addr    (col_idx),
    .pixel   (s_tdata),
    .wr_en   (advance_b),
    .wr_addr (idx_a),
    .mid     (mid_a),
    .top     (top_a)
  );

  // Line store stage: hold the pixel and its flags beside the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (accept) begin
      valid_a <= 1'b1;
    end else if (advance_b) begin
      valid_a <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_a   <= col_idx;
      info_a  <= info;
      pixel_a <= s_tdata;
    end
  end

  assign column_a.top = top_a;
  assign column_a.mid = mid_a;
  assign column_a.bot = pixel_a;

  lef3_kernel u_kernel (
    .clk        (clk),
    .rst        (rst),
    .shift      (advance_b),
    .col_in     (column_a),
    .max_level  (max_level),
    .edge_value (edge_value)
  );

  // Output register: load on advance (border pixels leave it empty), drop on take
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance_b) begin
      out_valid <= info_a.res;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_b) begin
      out_edge <= edge_value;
      out_last <= info_a.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_edge;
  assign m_tlast  = out_last;

`ifndef NO_ASSERTIONS
  // An empty line store stage must always take a pixel
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !valid_a |-> s_tready)
    else $error("s_tready low with empty line store stage");

  // A result only appears after the kernel stage advanced
  a_result_from_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(advance_b))
    else $error("result appeared without a kernel advance");

  // An accepted pixel always occupies the line store stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> valid_a)
    else $error("accepted pixel lost before the kernel stage");

  // A stalled result is never overwritten by an advance
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !advance_b)
    else $error("kernel stage advanced over a stalled result");
`endif

endmodule

`default_nettype wire

// ===== tb/lef3_edge_checker.sv =====
// Result checker for the 3x3 Laplacian edge filter: watches the configuration port
// and both streams, keeps its own copy of line stores, window and counters.
// Depends on lef3_pkg for the register index names.
`timescale 1ns / 1ps

module lef3_edge_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lef3_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [lef3_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] pixel
  input  logic                               s_tuser,   // frame_start
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [7:0]                         m_tdata,   // [7:0] edge_value
  input  logic                               m_tlast,   // last_of_frame
  output int                                 fail_count,
  output int                                 pending,
  output int                                 checked
);

  typedef struct packed {
    logic [7:0] edge_value;
    logic       last;
  } edge_result_t;

  edge_result_t edge_queue[$];

  lef3_pkg::pixel_t row_above     [MAX_WIDTH];
  lef3_pkg::pixel_t row_two_above [MAX_WIDTH];
  lef3_pkg::pixel_t win [3][3];
  int               col_cnt;
  int               row_cnt;
  logic [10:0]      width_reg;
  logic [10:0]      height_reg;
  logic [7:0]       level_reg;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic int clamp_dim(input logic [10:0] v, input int hi);
    if (v < 11'd3) return 3;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Level minus the 4-neighbour Laplacian clamped to 0..level
  function automatic logic [7:0] inverted_laplacian(input lef3_pkg::pixel_t up,
                                                    input lef3_pkg::pixel_t down,
                                                    input lef3_pkg::pixel_t lf,
                                                    input lef3_pkg::pixel_t rt,
                                                    input lef3_pkg::pixel_t ctr,
                                                    input logic [7:0] lvl);
    int s;
    s = int'(up) + int'(down) + int'(lf) + int'(rt) - 4 * int'(ctr);
    if (s < 0) s = 0;
    if (s > int'(lvl)) s = int'(lvl);
    return lvl - s[7:0];
  endfunction

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : track
    int               eff_w;
    int               eff_h;
    int               col;
    int               row;
    int               idx;
    lef3_pkg::pixel_t top_px;
    lef3_pkg::pixel_t mid_px;
    edge_result_t     want;
    if (rst) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i]     = '0;
        row_two_above[i] = '0;
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      width_reg  = 11'd640;
      height_reg = 11'd480;
      level_reg  = 8'd255;
      edge_queue.delete();
    end else begin
      if (cfg_we) begin
        case (lef3_pkg::cfg_reg_t'(cfg_addr))
          lef3_pkg::CFG_IMAGE_WIDTH:  width_reg  = cfg_wdata[10:0];
          lef3_pkg::CFG_IMAGE_HEIGHT: height_reg = cfg_wdata[10:0];
          lef3_pkg::CFG_MAX_LEVEL:    level_reg  = cfg_wdata[7:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        eff_w = clamp_dim(width_reg, MAX_WIDTH);
        eff_h = clamp_dim(height_reg, MAX_HEIGHT);
        if (s_tuser) begin
          col_cnt = 0;
          row_cnt = 0;
        end
        col = col_cnt;
        row = row_cnt;
        idx = col % MAX_WIDTH;

        top_px             = row_two_above[idx];
        mid_px             = row_above[idx];
        row_two_above[idx] = mid_px;
        row_above[idx]     = s_tdata;

        for (int r = 0; r < 3; r++) begin
          win[r][0] = win[r][1];
          win[r][1] = win[r][2];
        end
        win[0][2] = top_px;
        win[1][2] = mid_px;
        win[2][2] = s_tdata;

        if (row >= 2 && col >= 2 && col < eff_w && row < eff_h) begin
          want.edge_value = inverted_laplacian(win[0][1], win[2][1], win[1][0], win[1][2],
                                               win[1][1], level_reg);
          want.last       = (row == eff_h - 1) && (col == eff_w - 1);
          edge_queue.push_back(want);
        end

        // end the row at the last column, or past it after a width shrink
        if (col >= eff_w - 1) begin
          col_cnt = 0;
          row_cnt = (row >= eff_h - 1) ? 0 : row + 1;
        end else begin
          col_cnt = col + 1;
        end
      end

      if (m_tvalid && m_tready) begin
        if (edge_queue.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat edge=%0d last=%0b",
                                  m_tdata, m_tlast));
        end else begin
          want = edge_queue.pop_front();
          checked++;
          if (m_tdata !== want.edge_value)
            flag_mismatch($sformatf("edge_value expected %0d actual %0d",
                                    want.edge_value, m_tdata));
          if (m_tlast !== want.last)
            flag_mismatch($sformatf("last_of_frame expected %0b actual %0b",
                                    want.last, m_tlast));
        end
      end
    end
    pending = edge_queue.size();
  end

endmodule

// ===== tb/laplacian_edge_filter_3x3_core_tb.sv =====
// Top of the testbench for laplacian_edge_filter_3x3_core: clock, reset, pixel
// stimulus, receiver back-pressure and the verdict.
// Depends on lef3_pkg, the filter RTL and lef3_edge_checker.
`timescale 1ns / 1ps

module laplacian_edge_filter_3x3_core_tb;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int RANDOM_ITEMS = 1600;
  localparam int LONG_HOLD    = 300;
  localparam int PIPE_SETTLE  = 6;        // cycles for a no-result pixel to leave the pipe
  localparam int LIMIT        = 1000000;  // cycle budget for the whole run

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [lef3_pkg::CFG_IDX_W-1:0]      cfg_addr = '0;
  logic [lef3_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [7:0]                          s_tdata = '0;   // [7:0] pixel
  logic                                s_tuser = 1'b0; // frame_start
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [7:0]                          m_tdata;        // [7:0] edge_value
  logic                                m_tlast;        // last_of_frame

  int fail_count;
  int pending;
  int checked;

  // Stimulus control shared with the receiver process
  bit tx_gaps       = 1'b1;
  bit rx_gaps       = 1'b1;
  bit long_hold_req = 1'b0;

  int cycle_count  = 0;
  int pixels_sent  = 0;
  int phase_count  = 0;
  int mid_changes  = 0;

  laplacian_edge_filter_3x3_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  lef3_edge_checker #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Give up well past the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding", cycle_count,
               pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: ready stretches, random stall bursts, and one long hold on request.
  // Each pass drives tready once and then waits on the clock.
  initial begin
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic int eff_dim(input logic [10:0] v, input int hi);
    if (v < 11'd3) return 3;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Offer one pixel beat, maybe after a burst of idle cycles, and hold it until taken
  task automatic send_pixel(input lef3_pkg::pixel_t pix, input logic first);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // Drop valid and let every expected result out, then let stragglers clear the pipe
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; only call while idle
  task automatic load_config(input logic [10:0] w, input logic [10:0] h,
                             input logic [7:0] lvl);
    cfg_we    <= 1'b1;
    cfg_addr  <= lef3_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr  <= lef3_pkg::CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_addr  <= lef3_pkg::CFG_MAX_LEVEL;
    cfg_wdata <= {3'b000, lvl};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Two 3x3 frames, the second with no start mark: a peak (all neighbours high,
  // centre low) and a pit, driving the sum to both ends of its range
  lef3_pkg::pixel_t peak_pit [18] = '{
    8'h00, 8'hFF, 8'h00,  8'hFF, 8'h00, 8'hFF,  8'h00, 8'hFF, 8'h00,
    8'hFF, 8'h00, 8'hFF,  8'h00, 8'hFF, 8'h00,  8'hFF, 8'h00, 8'hFF};

  logic [10:0]      w_raw;
  logic [10:0]      h_raw;
  logic [7:0]       lvl;
  int               eff_w;
  int               eff_h;
  int               frame_len;
  int               n_pix;
  int               change_at;
  int               style;
  int               base;
  int               rand_pixels;
  bit               counts_random;
  lef3_pkg::pixel_t pix;
  logic             first;

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: smallest image, both sum extremes, a frame with no start mark
    load_config(11'd3, 11'd3, 8'd255);
    for (int i = 0; i < 18; i++) send_pixel(peak_pit[i], i == 0);
    wait_idle();

    // Directed: under-range sizes saturate to 3, zero level forces every result to 0
    load_config(11'd0, 11'd1, 8'd0);
    for (int i = 0; i < 9; i++)
      send_pixel(lef3_pkg::pixel_t'($urandom_range(0, 255)), i == 0);
    wait_idle();

    rand_pixels = 0;
    while (rand_pixels < RANDOM_ITEMS) begin
      phase_count++;
      counts_random = 1'b1;
      change_at     = -1;
      style         = $urandom_range(0, 2);
      base          = $urandom_range(0, 240);

      if (phase_count == 1) begin
        // Two full 16 x 8 images, so results keep coming behind the long receiver hold
        w_raw = 11'd16;
        h_raw = 11'd8;
        lvl   = 8'($urandom_range(1, 255));
        n_pix = 2 * 16 * 8;
      end else if (phase_count == 3) begin
        // Widest row (over-range width saturates), just into the first interior row
        w_raw = 11'h7FF;
        h_raw = 11'd3;
        lvl   = 8'($urandom_range(1, 255));
        n_pix = 2 * MAX_W + 40;
        counts_random = 1'b0;
      end else if (phase_count == 5) begin
        // Tallest image, saturated height, only the first rows of it
        w_raw = 11'd3;
        h_raw = 11'h7FF;
        lvl   = 8'd255;
        n_pix = 90;
        counts_random = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0:       w_raw = 11'($urandom_range(0, 2));
          1:       w_raw = 11'($urandom_range(17, 48));
          default: w_raw = 11'($urandom_range(3, 16));
        endcase
        case ($urandom_range(0, 9))
          0:       h_raw = 11'($urandom_range(0, 2));
          1:       h_raw = 11'($urandom_range(11, 16));
          default: h_raw = 11'($urandom_range(3, 10));
        endcase
        case ($urandom_range(0, 7))
          0:       lvl = 8'd0;
          1:       lvl = 8'd255;
          2:       lvl = 8'd1;
          default: lvl = 8'($urandom_range(0, 255));
        endcase
        if (w_raw > 11'd16 && h_raw > 11'd6) h_raw = 11'($urandom_range(3, 6));
        n_pix = $urandom_range(1, 3) * eff_dim(w_raw, MAX_W) * eff_dim(h_raw, MAX_H)
                + $urandom_range(0, eff_dim(w_raw, MAX_W));
        if ($urandom_range(0, 2) == 0) change_at = $urandom_range(1, n_pix - 1);
      end

      eff_w     = eff_dim(w_raw, MAX_W);
      eff_h     = eff_dim(h_raw, MAX_H);
      frame_len = eff_w * eff_h;
      load_config(w_raw, h_raw, lvl);

      for (int i = 0; i < n_pix; i++) begin
        // Last stretch of the run: no idling on either side
        if (counts_random && rand_pixels >= RANDOM_ITEMS - 200) begin
          tx_gaps = 1'b0;
          rx_gaps = 1'b0;
        end
        // Once interior results flow, hold the receiver off so the filter stalls its input
        if (phase_count == 1 && i == 3 * eff_w) long_hold_req = 1'b1;
        if (i == change_at) begin
          // Mid-image change: width may only shrink, height is drawn from 0..12, level goes anywhere
          wait_idle();
          load_config(11'($urandom_range(0, eff_w)), 11'($urandom_range(0, 12)),
                      8'($urandom_range(0, 255)));
          mid_changes++;
        end
        case (style)
          0:       pix = lef3_pkg::pixel_t'($urandom_range(0, 255));
          1:       pix = lef3_pkg::pixel_t'(base + $urandom_range(0, 15));
          default: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        // Mark the phase's first pixel; at later frame boundaries the mark is optional,
        // and a rare stray mark cuts a frame short
        if (i == 0)                  first = 1'b1;
        else if (i % frame_len == 0) first = 1'($urandom_range(0, 1));
        else                         first = ($urandom_range(0, 199) == 0);
        send_pixel(pix, first);
        if (counts_random) rand_pixels++;
      end
      wait_idle();
    end

    $display("Run covered %0d pixel beats in %0d random phases (%0d with a mid-image change),",
             pixels_sent, phase_count, mid_changes);
    $display("%0d edge results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
